// File: hw/rtl/lfo_pkg.sv
package lfo_pkg;

    // Parameter defaults
    localparam int PHASE_BITS_DEF    = 32;
    localparam int SINE_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Field widths
    localparam int FREQ_W     = 24;
    localparam int INC_W      = 24;
    localparam int PROD_W     = FREQ_W + INC_W;
    localparam int FRAC_BITS  = 12;
    localparam int TURN_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT_PER_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_FREQUENCY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PHASE      = 2'd2;

    // Register reset values
    localparam logic [INC_W-1:0]  INCREMENT_PER_HZ_RST = 24'd89478;
    localparam logic [FREQ_W-1:0] FIXED_FREQUENCY_RST  = 24'd4096;
    localparam logic [TURN_W-1:0] START_PHASE_RST      = 32'd0;

    // CORDIC: 1/gain * 2^30, arctangents in 2^32 per turn
    localparam int CORDIC_XY_W      = 34;
    localparam int TURN_TABLE_LEN   = 24;
    localparam int TURN_IDX_W       = $clog2(TURN_TABLE_LEN);
    localparam logic [31:0] CORDIC_X0 = 32'd652032874;

    localparam logic [TURN_W-1:0] TURN_ATAN [TURN_TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Sequencer to CORDIC request
    typedef struct packed {
        logic              start;
        logic [TURN_W-1:0] angle;
    } cordic_ctl_t;

endpackage

// File: hw/rtl/lfo_if.sv
interface lfo_in_if;
    import lfo_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [FREQ_W-1:0] tick_frequency;
    logic              block_end;

    modport source (output valid, output mode, output tick_frequency, output block_end,
                    input ready);
    modport sink   (input valid, input mode, input tick_frequency, input block_end,
                    output ready);
endinterface

interface lfo_out_if #(
    parameter int SINE_BITS = lfo_pkg::SINE_BITS_DEF
);
    import lfo_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [SINE_BITS-1:0] sine_sample;
    logic [TURN_W-1:0]           phase_now;
    logic                        block_end_out;

    modport source (output valid, output sine_sample, output phase_now,
                    output block_end_out, input ready);
    modport sink   (input valid, input sine_sample, input phase_now,
                    input block_end_out, output ready);
endinterface

// File: hw/rtl/lfo_cordic.sv
module lfo_cordic #(
    parameter int SINE_BITS     = lfo_pkg::SINE_BITS_DEF,
    parameter int CORDIC_STAGES = lfo_pkg::CORDIC_STAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfo_pkg::cordic_ctl_t        ctl,
    output logic                        done,
    output logic signed [SINE_BITS-1:0] sample
);
    import lfo_pkg::*;

    localparam int XY_W   = CORDIC_XY_W;
    localparam int ITER_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int SH     = 31 - SINE_BITS;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STAGES - 1);
    localparam logic signed [XY_W-1:0] ROUND_BIAS = XY_W'(1) << (SH - 1);
    localparam logic signed [XY_W-1:0] LIM = XY_W'((1 << (SINE_BITS - 1)) - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_ROUND
    } state_t;

    state_t                        state_reg, state_next;
    logic signed [XY_W-1:0]        x_reg, x_next;
    logic signed [XY_W-1:0]        y_reg, y_next;
    logic signed [XY_W-1:0]        z_reg, z_next;
    logic [ITER_W-1:0]             iter_reg, iter_next;
    logic                          neg_reg, neg_next;
    logic                          done_reg, done_next;
    logic signed [SINE_BITS-1:0]   sample_reg, sample_next;

    logic [1:0]                    quadrant;
    logic                          flip;
    logic [TURN_W-1:0]             a_fold;
    logic signed [XY_W-1:0]        dx, dy, atan_step;
    logic signed [XY_W-1:0]        rnd, rnd_signed;

    always_comb
    begin
        quadrant = ctl.angle[TURN_W-1:TURN_W-2];
        flip     = (quadrant == 2'd1) || (quadrant == 2'd2);
        a_fold   = flip ? ctl.angle + 32'h8000_0000 : ctl.angle;

        // shared shifter and add/sub unit, one micro-rotation per cycle
        dx        = y_reg >>> iter_reg;
        dy        = x_reg >>> iter_reg;
        atan_step = XY_W'(signed'({1'b0, TURN_ATAN[TURN_IDX_W'(iter_reg)]}));

        rnd        = (y_reg + ROUND_BIAS) >>> SH;
        rnd_signed = neg_reg ? -rnd : rnd;

        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        iter_next   = iter_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        sample_next = sample_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    x_next     = XY_W'(CORDIC_X0);
                    y_next     = '0;
                    z_next     = XY_W'(signed'(a_fold));
                    neg_next   = flip;
                    iter_next  = '0;
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                if (!z_reg[XY_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_step;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_step;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_signed > LIM)
                begin
                    sample_next = SINE_BITS'(LIM);
                end
                else if (rnd_signed < -LIM)
                begin
                    sample_next = SINE_BITS'(-LIM);
                end
                else
                begin
                    sample_next = SINE_BITS'(rnd_signed);
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        neg_reg    <= neg_next;
        sample_reg <= sample_next;
    end

    assign done   = done_reg;
    assign sample = sample_reg;

endmodule

// File: hw/rtl/lfo_sine_phase_accumulator_unit.sv
// Sine LFO: phase accumulator feeding an iterative CORDIC.
// A tick is taken only in IDLE, after the previous sample has been parked in the output
// register; the CORDIC runs one stage a cycle, and a finished sample waits in DONE while
// the output register is full.
// Reset: increment_per_hz = 89478, fixed_frequency = 4096 (1 Hz), start_phase = 0,
// phase accumulator = 0, no result pending.
module lfo_sine_phase_accumulator_unit #(
    parameter int PHASE_BITS    = lfo_pkg::PHASE_BITS_DEF,
    parameter int SINE_BITS     = lfo_pkg::SINE_BITS_DEF,
    parameter int CORDIC_STAGES = lfo_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [lfo_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [lfo_pkg::CFG_DATA_W-1:0]  wr_data,
    lfo_in_if.sink                          tick,
    lfo_out_if.source                       sample
);
    import lfo_pkg::*;

    // Sequencer:
    //   IDLE  - accept a tick, select frequency, multiply by increment_per_hz
    //   ADD   - accumulate truncated increment, wrap is implicit in the width
    //   START - hand the 32-bit phase to the CORDIC
    //   ROT   - CORDIC runs CORDIC_STAGES micro-rotations plus a rounding step
    //   DONE  - park the result in the output register once it is free
    // The output register lets a finished sample wait on the sink while the
    // next tick is accepted.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_START,
        ST_ROT,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;

    // Configuration registers
    logic [INC_W-1:0]            inc_per_hz_reg;
    logic [FREQ_W-1:0]           fixed_freq_reg;

    // Phase accumulator (control state: loaded by start_phase)
    logic [PHASE_BITS-1:0]       acc_reg;

    // Per-transaction payload
    logic [PROD_W-1:0]           prod_reg;
    logic                        block_end_reg;
    logic [TURN_W-1:0]           phase_now_reg;
    logic signed [SINE_BITS-1:0] out_sine_reg;
    logic [TURN_W-1:0]           out_phase_reg;
    logic                        out_block_end_reg;

    logic [FREQ_W-1:0]           sel_freq;
    logic [PHASE_BITS-1:0]       inc;
    logic [PHASE_BITS-1:0]       acc_sum;
    logic [TURN_W-1:0]           phase32;
    logic [PHASE_BITS-1:0]       start_load;
    logic                        in_accept;
    logic                        out_free;
    logic                        start_wr;
    cordic_ctl_t                 cordic_ctl;
    logic                        cordic_done;
    logic signed [SINE_BITS-1:0] cordic_sample;

    assign in_accept = tick.valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || sample.ready;
    assign start_wr  = wr_en && (wr_index == REG_START_PHASE);

    // Only the low bit of mode matters; it is a single bit here.
    assign sel_freq = tick.mode ? fixed_freq_reg : tick.tick_frequency;

    // Increment is (f * inc_per_hz) >> 12, reduced to the accumulator width.
    assign inc     = PHASE_BITS'(prod_reg >> FRAC_BITS);
    assign acc_sum = acc_reg + inc;

    // Align between the accumulator width and the 32-bit turn.
    generate
        if (PHASE_BITS >= TURN_W)
        begin : g_wide_phase
            assign phase32    = TURN_W'(acc_sum >> (PHASE_BITS - TURN_W));
            assign start_load = PHASE_BITS'(wr_data) << (PHASE_BITS - TURN_W);
        end
        else
        begin : g_narrow_phase
            assign phase32    = TURN_W'(acc_sum) << (TURN_W - PHASE_BITS);
            assign start_load = PHASE_BITS'(wr_data >> (TURN_W - PHASE_BITS));
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;

        if (sample.valid && sample.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (cordic_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= PHASE_BITS'(START_PHASE_RST);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // user must keep config writes to idle, so they never collide with ADD (not enforced)
            if (start_wr)
            begin
                acc_reg <= start_load;
            end
            else if (state_reg == ST_ADD)
            begin
                acc_reg <= acc_sum;
            end
        end
    end

    // Configuration write port; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_per_hz_reg <= INCREMENT_PER_HZ_RST;
            fixed_freq_reg <= FIXED_FREQUENCY_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_INCREMENT_PER_HZ: inc_per_hz_reg <= wr_data[INC_W-1:0];
                REG_FIXED_FREQUENCY:  fixed_freq_reg <= wr_data[FREQ_W-1:0];
                default:              ;
            endcase
        end
    end

    // Payload path, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prod_reg      <= PROD_W'(sel_freq) * PROD_W'(inc_per_hz_reg);
            block_end_reg <= tick.block_end;
        end
        if (state_reg == ST_ADD)
        begin
            phase_now_reg <= phase32;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_sine_reg      <= cordic_sample;
            out_phase_reg     <= phase_now_reg;
            out_block_end_reg <= block_end_reg;
        end
    end

    always_comb
    begin
        cordic_ctl.start = (state_reg == ST_START);
        cordic_ctl.angle = phase_now_reg;
    end

    lfo_cordic #(
        .SINE_BITS     (SINE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cordic_ctl),
        .done   (cordic_done),
        .sample (cordic_sample)
    );

    assign tick.ready           = (state_reg == ST_IDLE);
    assign sample.valid         = out_valid_reg;
    assign sample.sine_sample   = out_sine_reg;
    assign sample.phase_now     = out_phase_reg;
    assign sample.block_end_out = out_block_end_reg;

endmodule
